/* design/fifo_counting_semaphore_macros.svh */
// Assertion macros shared by the semaphore checker.
`ifndef FIFO_COUNTING_SEMAPHORE_MACROS_SVH
`define FIFO_COUNTING_SEMAPHORE_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define FCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/fcs_pkg.sv */
// Types, sizes and codes of the FIFO counting semaphore.
`timescale 1ns / 1ps

package fcs_pkg;

  localparam int DEPTH  = 16;
  localparam int UNIT_W = 16;
  localparam int ID_W   = 8;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic [UNIT_W-1:0] unit_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [1:0]        op_t;
  typedef logic [2:0]        kind_t;

  // operation codes
  localparam op_t OP_TRY     = 2'd0;
  localparam op_t OP_ACQUIRE = 2'd1;
  localparam op_t OP_RELEASE = 2'd2;
  localparam op_t OP_ABANDON = 2'd3;

  // result kinds
  localparam kind_t K_GRANTED    = 3'd0;
  localparam kind_t K_REFUSED    = 3'd1;
  localparam kind_t K_QUEUED     = 3'd2;
  localparam kind_t K_RELEASED   = 3'd3;
  localparam kind_t K_WITHDRAWN  = 3'd4;
  localparam kind_t K_NOT_QUEUED = 3'd5;
  localparam kind_t K_QUEUE_FULL = 3'd6;

  // controls broadcast to every waiter cell
  typedef struct packed {
    logic pop;
    logic remove;
    id_t  key;
  } fcs_cell_ctl_t;

  // command from the sequencer to the waiter queue
  typedef struct packed {
    logic  clear;
    logic  push;
    logic  pop;
    logic  remove;
    id_t   id;
    unit_t need;
  } fcs_q_cmd_t;

  // queue status seen by the sequencer
  typedef struct packed {
    cnt_t  count;
    logic  full;
    id_t   head_id;
    unit_t head_need;
    unit_t second_need;
    logic  found;
    logic  found_at_head;
    unit_t found_need;
  } fcs_q_stat_t;

endpackage

/* design/fcs_if.sv */
// Valid/ready channel interfaces: request, result and configuration.
`timescale 1ns / 1ps

interface fcs_in_if import fcs_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   op;
  id_t   requester_id;
  unit_t amount;

  modport source (output valid, output op, output requester_id, output amount, input ready);
  modport sink   (input valid, input op, input requester_id, input amount, output ready);
endinterface

interface fcs_out_if import fcs_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  id_t   granted_id;
  unit_t granted_amount;
  unit_t units_left;
  logic  saturated;
  logic  last;

  modport source (output valid, output kind, output granted_id, output granted_amount,
                  output units_left, output saturated, output last, input ready);
  modport sink   (input valid, input kind, input granted_id, input granted_amount,
                  input units_left, input saturated, input last, output ready);
endinterface

interface fcs_cfg_if import fcs_pkg::*; ();
  logic  valid;
  logic  ready;
  unit_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/fcs_cell.sv */
// One waiter slot of the queue: holds an id and a need, shifts toward the head.
`timescale 1ns / 1ps

module fcs_cell import fcs_pkg::*; (
  input  logic          clk,
  input  fcs_cell_ctl_t ctl,
  input  logic          occ,
  input  logic          load,
  input  id_t           load_id,
  input  unit_t         load_need,
  input  id_t           nbr_id,
  input  unit_t         nbr_need,
  input  logic          hit_in,
  output logic          hit_out,
  output logic          first,
  output id_t           id,
  output unit_t         need
);

  id_t   id_r;
  unit_t need_r;
  logic  match;
  logic  shift;

  // match on the abandon key; the hit chain marks the oldest match and all behind it
  assign match   = occ && (id_r == ctl.key);
  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;
  assign shift   = ctl.pop | (ctl.remove & hit_out);

  always_ff @(posedge clk) begin
    if (load) begin
      id_r   <= load_id;
      need_r <= load_need;
    end else if (shift) begin
      id_r   <= nbr_id;
      need_r <= nbr_need;
    end
  end

  assign id   = id_r;
  assign need = need_r;

endmodule

/* design/fcs_queue.sv */
// Waiter FIFO built as a row of cells with a fill count.
`timescale 1ns / 1ps

module fcs_queue import fcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fcs_q_cmd_t  cmd,
  output fcs_q_stat_t stat
);

  cnt_t          count_r, count_nxt;
  id_t           cell_id   [DEPTH];
  unit_t         cell_need [DEPTH];
  id_t           nbr_id    [DEPTH];
  unit_t         nbr_need  [DEPTH];
  logic          first     [DEPTH];
  logic          hit_chain [DEPTH+1];
  fcs_cell_ctl_t cell_ctl;
  unit_t         found_need;

  assign cell_ctl.pop    = cmd.pop;
  assign cell_ctl.remove = cmd.remove;
  assign cell_ctl.key    = cmd.id;
  assign hit_chain[0]    = 1'b0;

  // row of cells, each fed by its neighbour on the tail side
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      assign nbr_id[i]   = '0;
      assign nbr_need[i] = '0;
    end else begin : g_mid
      assign nbr_id[i]   = cell_id[i+1];
      assign nbr_need[i] = cell_need[i+1];
    end

    fcs_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .occ       (count_r > CNT_W'(i)),
      .load      (cmd.push && (count_r == CNT_W'(i))),
      .load_id   (cmd.id),
      .load_need (cmd.need),
      .nbr_id    (nbr_id[i]),
      .nbr_need  (nbr_need[i]),
      .hit_in    (hit_chain[i]),
      .hit_out   (hit_chain[i+1]),
      .first     (first[i]),
      .id        (cell_id[i]),
      .need      (cell_need[i])
    );
  end

  // the entry next to the head, zero when there is none
  if (DEPTH > 1) begin : g_second
    assign stat.second_need = cell_need[1];
  end else begin : g_no_second
    assign stat.second_need = '0;
  end

  // need of the oldest matching waiter (one-hot select)
  always_comb begin
    found_need = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) found_need = found_need | cell_need[i];
    end
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    priority if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop || (cmd.remove && hit_chain[DEPTH])) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.count         = count_r;
  assign stat.full          = (count_r == CNT_W'(DEPTH));
  assign stat.head_id       = cell_id[0];
  assign stat.head_need     = cell_need[0];
  assign stat.found         = hit_chain[DEPTH];
  assign stat.found_at_head = first[0];
  assign stat.found_need    = found_need;

endmodule

/* design/fifo_counting_semaphore.sv */
// A request's first result is registered and is on the output in the cycle after it is taken.
// Single-result operations take one request a cycle while the output is not stalled.
// Grants after a release or withdrawal go from the head cell one a cycle while not stalled.
// Reset: synchronous, active low; free count 0, queue empty, output channel empty.
// A configuration write loads the free count and empties the queue.
`timescale 1ns / 1ps

module fifo_counting_semaphore import fcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fcs_in_if.sink    in_ch,
  fcs_out_if.source out_ch,
  fcs_cfg_if.sink   cfg_ch
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_GRANT = 1'b1;

  logic        state_r, state_nxt;
  unit_t       free_r, free_nxt;
  logic        out_valid_r;
  kind_t       kind_r;
  id_t         id_r;
  unit_t       amount_r;
  unit_t       left_r;
  logic        sat_r;
  logic        last_r;

  fcs_q_cmd_t  q_cmd;
  fcs_q_stat_t q_stat;

  logic        slot_free;
  logic        in_fire;
  logic        cfg_fire;
  logic        res_load;
  kind_t       res_kind;
  id_t         res_id;
  unit_t       res_amount;
  logic        res_sat;
  logic        res_last;
  logic [UNIT_W:0] rel_sum;
  unit_t       rel_free;
  unit_t       grant_rem;
  unit_t       next_head_need;

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && slot_free;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // release sum, clipped at the maximum count
  assign rel_sum  = {1'b0, free_r} + {1'b0, in_ch.amount};
  assign rel_free = rel_sum[UNIT_W] ? '1 : rel_sum[UNIT_W-1:0];

  // head after a withdrawal, and free count after granting the head
  assign next_head_need = q_stat.found_at_head ? q_stat.second_need : q_stat.head_need;
  assign grant_rem      = free_r - q_stat.head_need;

  // sequencer: decode a request, then walk grants off the head
  always_comb begin
    state_nxt   = state_r;
    free_nxt    = free_r;
    q_cmd       = '0;
    q_cmd.id    = in_ch.requester_id;
    q_cmd.need  = in_ch.amount;
    res_load    = 1'b0;
    res_kind    = K_GRANTED;
    res_id      = in_ch.requester_id;
    res_amount  = in_ch.amount;
    res_sat     = 1'b0;
    res_last    = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          unique case (in_ch.op)
            OP_TRY, OP_ACQUIRE: begin
              priority if ((q_stat.count == '0) && (free_r >= in_ch.amount)) begin
                res_kind = K_GRANTED;
                free_nxt = free_r - in_ch.amount;
              end else if (in_ch.op == OP_TRY) begin
                res_kind = K_REFUSED;
              end else if (q_stat.full) begin
                res_kind = K_QUEUE_FULL;
              end else begin
                res_kind   = K_QUEUED;
                q_cmd.push = 1'b1;
              end
            end
            OP_RELEASE: begin
              res_kind = K_RELEASED;
              res_sat  = rel_sum[UNIT_W];
              free_nxt = rel_free;
              res_last = !((q_stat.count != '0) && (q_stat.head_need <= rel_free));
              if (!res_last) state_nxt = ST_GRANT;
            end
            OP_ABANDON: begin
              q_cmd.remove = 1'b1;
              if (q_stat.found) begin
                res_kind   = K_WITHDRAWN;
                res_amount = q_stat.found_need;
                res_last   = !((q_stat.count > CNT_W'(1)) && (next_head_need <= free_r));
                if (!res_last) state_nxt = ST_GRANT;
              end else begin
                res_kind   = K_NOT_QUEUED;
                res_amount = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_GRANT: begin
        if (slot_free) begin
          res_load   = 1'b1;
          q_cmd.pop  = 1'b1;
          res_kind   = K_GRANTED;
          res_id     = q_stat.head_id;
          res_amount = q_stat.head_need;
          free_nxt   = grant_rem;
          res_last   = !((q_stat.count > CNT_W'(1)) && (q_stat.second_need <= grant_rem));
          if (res_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // register write reloads the count and empties the queue
    if (cfg_fire) begin
      free_nxt    = cfg_ch.data;
      q_cmd.clear = 1'b1;
      q_cmd.push  = 1'b0;
      q_cmd.pop   = 1'b0;
      q_cmd.remove = 1'b0;
      state_nxt   = ST_IDLE;
    end
  end

  fcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q_cmd),
    .stat  (q_stat)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      kind_r   <= res_kind;
      id_r     <= res_id;
      amount_r <= res_amount;
      left_r   <= free_nxt;
      sat_r    <= res_sat;
      last_r   <= res_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.granted_id     = id_r;
  assign out_ch.granted_amount = amount_r;
  assign out_ch.units_left     = left_r;
  assign out_ch.saturated      = sat_r;
  assign out_ch.last           = last_r;

endmodule

/* design/fcs_checker.sv */
// Port-level checker for the semaphore, bound to the top level.
`timescale 1ns / 1ps
`include "fifo_counting_semaphore_macros.svh"

module fcs_checker import fcs_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input kind_t out_kind,
  input unit_t out_amount,
  input logic  out_sat,
  input logic  out_last
);

  // a stalled result holds
  `FCS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_amount) && $stable(out_last), "result changed while stalled")

  // no new request while a multi-result transaction is still being delivered
  `FCS_ASSERT(a_no_overlap, out_valid && !out_last |-> !in_ready, "request taken mid-sequence")

  // only a release can be clipped
  `FCS_ASSERT(a_sat_release, out_valid && out_sat |-> out_kind == K_RELEASED, "saturated on a non-release")

  // an absent waiter ends its transaction with nothing withdrawn
  `FCS_ASSERT(a_not_queued, out_valid && out_kind == K_NOT_QUEUED |-> out_last && out_amount == '0, "bad not_queued result")

  // output channel empty straight after reset
  `FCS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind fifo_counting_semaphore fcs_checker u_fcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.kind),
  .out_amount (out_ch.granted_amount),
  .out_sat    (out_ch.saturated),
  .out_last   (out_ch.last)
);

/* bench/tb_fifo_counting_semaphore.sv */
// Self-checking bench for the FIFO counting semaphore: directed table, then random phases.
`timescale 1ns / 1ps

module tb_fifo_counting_semaphore import fcs_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;

  // one expected result transaction
  typedef struct packed {
    kind_t kind;
    id_t   id;
    unit_t amt;
    unit_t left;
    logic  sat;
    logic  last;
  } outcome_t;

  // one queued waiter as the bench sees it
  typedef struct packed {
    id_t   id;
    unit_t need;
  } waiter_t;

  // directed row: request plus the first result where it is obvious
  typedef struct packed {
    op_t   op;
    id_t   id;
    unit_t amt;
    logic  typed;
    kind_t kind;
    unit_t left;
  } row_t;

  logic clk;
  logic rst_n;

  fcs_in_if  in_if();
  fcs_out_if out_if();
  fcs_cfg_if cfg_if();

  fifo_counting_semaphore uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // semaphore shadow state
  unit_t    free_cnt = '0;
  waiter_t  waiters[$];
  outcome_t outcome_q[$];

  // result of the current request, held back until we know whether it is the last
  outcome_t held;
  logic     held_ok = 1'b0;
  logic     first_res;
  logic     row_typed = 1'b0;
  kind_t    row_kind;
  unit_t    row_left;

  logic        gaps_on = 1'b1;
  int          fails = 0;
  int unsigned cycle_cnt = 0;
  outcome_t    seen;

  // stimulus table: reset state, zero amount, duplicates, queue full, absent abandon,
  // withdrawal followed by a grant pass, full-scale release, saturation
  row_t plan [25] = '{
    '{OP_ACQUIRE, 8'h01, 16'd0,     1'b1, K_GRANTED,    16'd0},
    '{OP_TRY,     8'h02, 16'd1,     1'b1, K_REFUSED,    16'd0},
    '{OP_ACQUIRE, 8'h03, 16'd5,     1'b1, K_QUEUED,     16'd0},
    '{OP_TRY,     8'h04, 16'd0,     1'b1, K_REFUSED,    16'd0},
    '{OP_ACQUIRE, 8'h05, 16'd0,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h03, 16'd2,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h40, 16'd1,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h41, 16'd2,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h42, 16'd3,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h43, 16'd4,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h44, 16'd5,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h45, 16'd6,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h46, 16'd7,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h47, 16'd8,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h48, 16'd9,     1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h49, 16'd10,    1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h4A, 16'd11,    1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h4B, 16'd12,    1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h4C, 16'd13,    1'b1, K_QUEUED,     16'd0},
    '{OP_ACQUIRE, 8'h7F, 16'd0,     1'b1, K_QUEUE_FULL, 16'd0},
    '{OP_ABANDON, 8'hFF, 16'h1234,  1'b1, K_NOT_QUEUED, 16'd0},
    '{OP_ABANDON, 8'h03, 16'd0,     1'b1, K_WITHDRAWN,  16'd0},
    '{OP_RELEASE, 8'hAA, 16'hFFFF,  1'b1, K_RELEASED,   16'hFFFF},
    '{OP_RELEASE, 8'h55, 16'hFFFF,  1'b1, K_RELEASED,   16'hFFFF},
    '{OP_TRY,     8'h80, 16'hFFFF,  1'b1, K_GRANTED,    16'd0}
  };

  // clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // queue one expected result; the previous one is now known not to be last
  function automatic void post(kind_t k, id_t rid, unit_t amt, logic sat);
    outcome_t r;
    r.kind = k;
    r.id   = rid;
    r.amt  = amt;
    r.left = free_cnt;
    r.sat  = sat;
    r.last = 1'b0;
    if (first_res && row_typed) begin
      r.kind = row_kind;
      r.left = row_left;
    end
    first_res = 1'b0;
    if (held_ok)
      outcome_q.push_back(held);
    held    = r;
    held_ok = 1'b1;
  endfunction

  // grant waiters from the head while the head's need fits
  function automatic void serve_head();
    waiter_t w;
    while (waiters.size() > 0 && waiters[0].need <= free_cnt) begin
      w = waiters.pop_front();
      free_cnt = free_cnt - w.need;
      post(K_GRANTED, w.id, w.need, 1'b0);
    end
  endfunction

  // semaphore behaviour for one accepted request
  function automatic void predict_request(op_t op, id_t rid, unit_t amt);
    logic [UNIT_W:0] sum;
    logic            sat;
    int              pos;
    unit_t           need;
    waiter_t         w;
    first_res = 1'b1;
    case (op)
      OP_TRY, OP_ACQUIRE: begin
        if (waiters.size() == 0 && free_cnt >= amt) begin
          free_cnt = free_cnt - amt;
          post(K_GRANTED, rid, amt, 1'b0);
        end else if (op == OP_TRY) begin
          post(K_REFUSED, rid, amt, 1'b0);
        end else if (waiters.size() >= DEPTH) begin
          post(K_QUEUE_FULL, rid, amt, 1'b0);
        end else begin
          w.id   = rid;
          w.need = amt;
          waiters.push_back(w);
          post(K_QUEUED, rid, amt, 1'b0);
        end
      end
      OP_RELEASE: begin
        sum = {1'b0, free_cnt} + {1'b0, amt};
        sat = sum[UNIT_W];
        free_cnt = sat ? '1 : sum[UNIT_W-1:0];
        post(K_RELEASED, rid, amt, sat);
        serve_head();
      end
      default: begin
        // oldest matching waiter goes
        pos = -1;
        for (int i = 0; i < waiters.size(); i++)
          if (pos < 0 && waiters[i].id == rid)
            pos = i;
        if (pos < 0) begin
          post(K_NOT_QUEUED, rid, '0, 1'b0);
        end else begin
          need = waiters[pos].need;
          waiters.delete(pos);
          post(K_WITHDRAWN, rid, need, 1'b0);
          serve_head();
        end
      end
    endcase
    held.last = 1'b1;
    outcome_q.push_back(held);
    held_ok = 1'b0;
  endfunction

  function automatic void cmp(string name, logic [UNIT_W-1:0] exp_v, logic [UNIT_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endfunction

  // present one request, optionally after a short gap, and hold it until taken
  task automatic issue(op_t op, id_t rid, unit_t amt);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.op           <= op;
    in_if.requester_id <= rid;
    in_if.amount       <= amt;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_request(op, rid, amt);
  endtask

  // load the unit count once everything outstanding has drained
  task automatic load_units(unit_t v);
    in_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    free_cnt = v;
    waiters.delete();
  endtask

  // result side back-pressure
  initial begin
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result: kind %0d id %0d amount %0d", out_if.kind,
               out_if.granted_id, out_if.granted_amount);
        fails++;
      end else begin
        seen = outcome_q.pop_front();
        cmp("kind", UNIT_W'(seen.kind), UNIT_W'(out_if.kind));
        cmp("granted_id", UNIT_W'(seen.id), UNIT_W'(out_if.granted_id));
        cmp("granted_amount", seen.amt, out_if.granted_amount);
        cmp("units_left", seen.left, out_if.units_left);
        cmp("saturated", UNIT_W'(seen.sat), UNIT_W'(out_if.saturated));
        cmp("last", UNIT_W'(seen.last), UNIT_W'(out_if.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_fifo_counting_semaphore: done, errors");
      $finish;
    end
  end

  // main sequence
  initial begin
    unit_t level;
    unit_t scale;
    op_t   op;
    id_t   rid;
    unit_t amt;
    int    r;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.op           <= OP_TRY;
    in_if.requester_id <= '0;
    in_if.amount       <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table against the reset state
    foreach (plan[i]) begin
      row_typed = plan[i].typed;
      row_kind  = plan[i].kind;
      row_left  = plan[i].left;
      issue(plan[i].op, plan[i].id, plan[i].amt);
    end
    row_typed = 1'b0;

    // random phases at several unit counts; the last runs without gaps
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          level = 16'd8;
          scale = 16'd15;
        end
        1: begin
          level = 16'hFFFF;
          scale = 16'hFFFF;
        end
        2: begin
          level = 16'd0;
          scale = 16'd6;
        end
        3: begin
          level = 16'd30;
          scale = 16'd40;
        end
        default: begin
          level = unit_t'($urandom_range(1, 200));
          scale = 16'd60;
        end
      endcase
      gaps_on = (ph != 4);
      load_units(level);
      repeat (41) begin
        r = $urandom_range(0, 99);
        if (r < 15)
          op = OP_TRY;
        else if (r < 50)
          op = OP_ACQUIRE;
        else if (r < 75)
          op = OP_RELEASE;
        else
          op = OP_ABANDON;
        // abandons mostly target a real waiter; small ids give duplicates
        if (op == OP_ABANDON && waiters.size() > 0 && $urandom_range(0, 3) != 0)
          rid = waiters[$urandom_range(0, waiters.size() - 1)].id;
        else if ($urandom_range(0, 3) == 0)
          rid = id_t'($urandom);
        else
          rid = id_t'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0:       amt = '0;
          1:       amt = '1;
          default: amt = unit_t'($urandom_range(0, scale));
        endcase
        issue(op, rid, amt);
      end
    end

    // drain and let the block settle
    in_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("tb_fifo_counting_semaphore: done, clean");
    else
      $display("tb_fifo_counting_semaphore: done, errors");
    $finish;
  end

endmodule
